FILE: src/kmp_pattern_match_counter_top_macros.svh
// Assertion macros used by the port-level checker of the pattern match counter.
`ifndef KMP_PATTERN_MATCH_COUNTER_TOP_MACROS_SVH
`define KMP_PATTERN_MATCH_COUNTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPMC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KPMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/kpmc_pkg.sv
// Shared constants and types of the pattern match counter.
package kpmc_pkg;

    localparam int MAX_PATTERN_DEF   = 64;
    localparam int POSITION_BITS_DEF = 32;
    localparam int SYM_W             = 8;
    localparam int OUT_W             = 32;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    typedef struct packed {
        logic             match_found;
        logic [OUT_W-1:0] match_start;
        logic [OUT_W-1:0] match_total;
        logic             text_done;
    } kpmc_result_t;

endpackage

FILE: src/kpmc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module kpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/kpmc_core.sv
// Sequencer that builds the failure table and walks the matcher over the memories.
module kpmc_core
    import kpmc_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int IDX_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic               in_kind,
    input  logic [SYM_W-1:0]   in_symbol,
    input  logic               in_last,
    output logic               in_ready,
    input  logic               out_free,
    output logic               res_load,
    output kpmc_result_t       res,
    output logic [IDX_W-1:0]   rd_addr,
    input  logic [SYM_W-1:0]   pat_rdata,
    input  logic [IDX_W-1:0]   fail_rdata,
    output logic               pat_we,
    output logic [IDX_W-1:0]   pat_waddr,
    output logic [SYM_W-1:0]   pat_wdata,
    output logic               fail_we,
    output logic [IDX_W-1:0]   fail_waddr,
    output logic [IDX_W-1:0]   fail_wdata
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int POS_W = POSITION_BITS;
    localparam int SW    = (POSITION_BITS < OUT_W) ? POSITION_BITS : OUT_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]   cand_reg, cand_next;
    logic [IDX_W-1:0]   matched_reg, matched_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [OUT_W-1:0]   count_reg, count_next;
    logic               fresh_reg, fresh_next;
    logic               kind_reg, kind_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic               last_reg, last_next;

    logic               accept;
    logic               load_at_zero;
    logic               load_full;
    logic               p_hit;
    logic               step_fail;
    logic [LEN_W-1:0]   k_inc;
    logic [LEN_W-1:0]   len_inc;
    logic               emit;
    logic               found;
    logic [IDX_W-1:0]   new_match;
    logic               cur_last;
    logic [POS_W-1:0]   start_full;
    logic [OUT_W-1:0]   count_inc;
    logic [OUT_W-1:0]   total;

    assign in_ready     = (state_reg == ST_IDLE) && out_free;
    assign accept       = in_valid && in_ready;
    assign load_at_zero = fresh_reg || (len_reg == '0);
    assign load_full    = !fresh_reg && (len_reg == LEN_MAX);
    assign p_hit        = (pat_rdata == sym_reg);
    assign step_fail    = (k_reg != '0) && !p_hit;
    assign k_inc        = LEN_W'(k_reg) + (p_hit ? LEN_W'(1) : LEN_W'(0));
    assign len_inc      = len_reg + LEN_W'(1);
    assign cur_last     = (state_reg == ST_IDLE) ? in_last : last_reg;
    assign start_full   = pos_reg + POS_W'(1) - POS_W'(len_reg);
    assign count_inc    = (count_reg != '1) ? (count_reg + OUT_W'(1)) : count_reg;
    assign total        = found ? count_inc : count_reg;
    assign rd_addr      = k_next;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        len_next     = len_reg;
        cand_next    = cand_reg;
        matched_next = matched_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        kind_next    = kind_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        pat_we       = 1'b0;
        pat_waddr    = '0;
        pat_wdata    = sym_reg;
        fail_we      = 1'b0;
        fail_waddr   = '0;
        fail_wdata   = '0;
        emit         = 1'b0;
        found        = 1'b0;
        new_match    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next = in_kind;
                    sym_next  = in_symbol;
                    last_next = in_last;
                    if (in_kind == KIND_PATTERN) begin
                        fresh_next   = in_last;
                        matched_next = '0;
                        if (load_at_zero) begin
                            pat_we     = 1'b1;
                            pat_waddr  = '0;
                            pat_wdata  = in_symbol;
                            fail_we    = (MAX_PATTERN > 1);
                            fail_waddr = IDX_W'(1);
                            fail_wdata = '0;
                            len_next   = LEN_W'(1);
                            cand_next  = '0;
                        end else if (!load_full) begin
                            k_next     = cand_reg;
                            state_next = ST_WALK;
                        end
                    end else begin
                        if (len_reg == '0) begin
                            emit = 1'b1;
                        end else begin
                            k_next     = matched_reg;
                            state_next = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (step_fail) begin
                    k_next = fail_rdata;
                end else if (kind_reg == KIND_PATTERN) begin
                    pat_we     = 1'b1;
                    pat_waddr  = IDX_W'(len_reg);
                    pat_wdata  = sym_reg;
                    fail_we    = (len_inc != LEN_MAX);
                    fail_waddr = IDX_W'(len_inc);
                    fail_wdata = IDX_W'(k_inc);
                    cand_next  = IDX_W'(k_inc);
                    len_next   = len_inc;
                    state_next = ST_IDLE;
                end else begin
                    emit       = 1'b1;
                    found      = (k_inc == len_reg);
                    new_match  = (k_inc == len_reg) ? cand_reg : IDX_W'(k_inc);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            if (cur_last) begin
                pos_next     = '0;
                count_next   = '0;
                matched_next = '0;
            end else begin
                pos_next     = pos_reg + POS_W'(1);
                count_next   = total;
                matched_next = new_match;
            end
        end
    end

    always_comb begin
        res_load          = emit;
        res.match_found   = found;
        res.match_start   = found ? OUT_W'(start_full[SW-1:0]) : '0;
        res.match_total   = total;
        res.text_done     = cur_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            cand_reg    <= '0;
            matched_reg <= '0;
            pos_reg     <= '0;
            count_reg   <= '0;
            fresh_reg   <= 1'b1;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cand_reg    <= cand_next;
            matched_reg <= matched_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        kind_reg <= kind_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
    end

endmodule

FILE: src/kmp_pattern_match_counter_top.sv
// Top level of the KMP pattern match counter with its result register.
//
//   Channel  Direction  Transaction              Ports
//   s_       in         one pattern or text byte s_valid s_ready s_kind s_symbol s_last
//   m_       out        one result per text byte m_valid m_ready m_match_found
//                                                m_match_start m_match_total m_text_done
//
// A first pattern byte, a pattern byte past the store limit and a text byte against an
// empty pattern are finished in the idle state. Any other byte also passes the walk state,
// stepping down the failure chain, each step one read of the pattern and failure memories.
// There is no clearing pass after reset; the memories are only read below the length.
// s_ready is low while a byte is being worked on and while a result waits unaccepted.
module kmp_pattern_match_counter_top
    import kpmc_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_kind,
    input  logic [SYM_W-1:0] s_symbol,
    input  logic             s_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_match_found,
    output logic [OUT_W-1:0] m_match_start,
    output logic [OUT_W-1:0] m_match_total,
    output logic             m_text_done
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic             out_free;
    logic             res_load;
    kpmc_result_t     res;
    kpmc_result_t     res_reg;
    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] rd_addr;
    logic [SYM_W-1:0] pat_rdata;
    logic [IDX_W-1:0] fail_rdata;
    logic             pat_we;
    logic [IDX_W-1:0] pat_waddr;
    logic [SYM_W-1:0] pat_wdata;
    logic             fail_we;
    logic [IDX_W-1:0] fail_waddr;
    logic [IDX_W-1:0] fail_wdata;

    assign out_free = !m_valid_reg || m_ready;

    kpmc_core #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_kind    (s_kind),
        .in_symbol  (s_symbol),
        .in_last    (s_last),
        .in_ready   (s_ready),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res),
        .rd_addr    (rd_addr),
        .pat_rdata  (pat_rdata),
        .fail_rdata (fail_rdata),
        .pat_we     (pat_we),
        .pat_waddr  (pat_waddr),
        .pat_wdata  (pat_wdata),
        .fail_we    (fail_we),
        .fail_waddr (fail_waddr),
        .fail_wdata (fail_wdata)
    );

    kpmc_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .aclk  (aclk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .raddr (rd_addr),
        .rdata (pat_rdata)
    );

    // Entry k of the failure memory holds the border of the prefix of length k.
    kpmc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PATTERN)
    ) u_fail_ram (
        .aclk  (aclk),
        .we    (fail_we),
        .waddr (fail_waddr),
        .wdata (fail_wdata),
        .raddr (rd_addr),
        .rdata (fail_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_found = res_reg.match_found;
    assign m_match_start = res_reg.match_start;
    assign m_match_total = res_reg.match_total;
    assign m_text_done   = res_reg.text_done;

endmodule

FILE: src/kpmc_checker.sv
// Port-level checker of the pattern match counter and its bind to the top level.
`include "kmp_pattern_match_counter_top_macros.svh"

module kpmc_checker
    import kpmc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_kind,
    input logic [SYM_W-1:0] s_symbol,
    input logic             s_last,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_match_found,
    input logic [OUT_W-1:0] m_match_start,
    input logic [OUT_W-1:0] m_match_total,
    input logic             m_text_done
);

    `KPMC_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_match_start) && $stable(m_match_total) && $stable(m_match_found) && $stable(m_text_done), "Stalled result transaction changed.")
    `KPMC_ASSERT_SAME(a_no_accept_on_stall, m_valid && !m_ready, !s_ready, "Input transaction taken while a result waits.")
    `KPMC_ASSERT_NEXT(a_pattern_no_result, s_valid && s_ready && (s_kind == KIND_PATTERN), !m_valid, "Pattern byte produced a result.")
    `KPMC_ASSERT_SAME(a_match_consistent, m_valid && m_match_found, m_match_total != '0, "Match reported with a zero total.")
    `KPMC_ASSERT_SAME(a_start_zero, m_valid && !m_match_found, m_match_start == '0, "Start offset set without a match.")

endmodule

bind kmp_pattern_match_counter_top kpmc_checker u_kpmc_checker (.*);

FILE: tb/kmp_pattern_match_counter_checker.sv
// Checker that predicts and compares every result of the KMP pattern match counter.
module kmp_pattern_match_counter_checker
    import kpmc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             s_kind,
    input  logic [SYM_W-1:0] s_symbol,
    input  logic             s_last,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic             m_match_found,
    input  logic [OUT_W-1:0] m_match_start,
    input  logic [OUT_W-1:0] m_match_total,
    input  logic             m_text_done,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = MAX_PATTERN_DEF;

    logic [SYM_W-1:0] pattern_mem [DEPTH];
    logic [5:0]       border_mem [DEPTH];
    logic [6:0]       pat_size;
    logic [6:0]       border_cand;
    logic [6:0]       prefix_len;
    logic [OUT_W-1:0] text_offset;
    logic [OUT_W-1:0] match_count;
    logic             load_fresh;
    kpmc_result_t     reports_due [$];
    kpmc_result_t     due;

    task automatic add_pattern_byte(input logic [SYM_W-1:0] sym);
        int k;
        if (pat_size >= DEPTH) return;
        k = border_cand;
        pattern_mem[pat_size] = sym;
        if (pat_size == 0) begin
            border_mem[0] = '0;
            border_cand = '0;
            pat_size = 7'd1;
            return;
        end
        while (k > 0 && pattern_mem[k] != sym) k = border_mem[k-1];
        if (pattern_mem[k] == sym) k++;
        border_mem[pat_size] = 6'(k);
        border_cand = 7'(k);
        pat_size = pat_size + 7'd1;
    endtask

    task automatic scan_text_byte(input logic [SYM_W-1:0] sym, input logic last);
        int j;
        int len;
        kpmc_result_t res;
        j = prefix_len;
        len = pat_size;
        res = '0;
        if (len > 0) begin
            if (j >= len) j = 0;
            while (j > 0 && pattern_mem[j] != sym) j = border_mem[j-1];
            if (pattern_mem[j] == sym) j++;
            if (j == len) begin
                res.match_found = 1'b1;
                res.match_start = text_offset + 32'd1 - 32'(len);
                if (match_count != '1) match_count = match_count + OUT_W'(1);
                j = border_mem[j-1];
            end
        end else begin
            j = 0;
        end
        prefix_len = 7'(j);
        res.match_total = match_count;
        res.text_done = last;
        reports_due.push_back(res);
        text_offset = text_offset + OUT_W'(1);
        if (last) begin
            text_offset = '0;
            match_count = '0;
            prefix_len = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_size = '0;
            border_cand = '0;
            prefix_len = '0;
            text_offset = '0;
            match_count = '0;
            load_fresh = 1'b1;
            reports_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    $error("Result transaction arrived with no expectation waiting.");
                    mismatches++;
                end else begin
                    due = reports_due.pop_front();
                    if (m_match_found !== due.match_found) begin
                        $error("match_found: expected %0d, actual %0d",
                               due.match_found, m_match_found);
                        mismatches++;
                    end
                    if (m_match_start !== due.match_start) begin
                        $error("match_start: expected %0d, actual %0d",
                               due.match_start, m_match_start);
                        mismatches++;
                    end
                    if (m_match_total !== due.match_total) begin
                        $error("match_total: expected %0d, actual %0d",
                               due.match_total, m_match_total);
                        mismatches++;
                    end
                    if (m_text_done !== due.text_done) begin
                        $error("text_done: expected %0d, actual %0d",
                               due.text_done, m_text_done);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_kind == KIND_PATTERN) begin
                    if (load_fresh) begin
                        pat_size = '0;
                        border_cand = '0;
                        load_fresh = 1'b0;
                    end
                    add_pattern_byte(s_symbol);
                    prefix_len = '0;
                    if (s_last) load_fresh = 1'b1;
                end else begin
                    scan_text_byte(s_symbol, s_last);
                end
            end
            outstanding <= reports_due.size();
        end
    end

endmodule

FILE: tb/tb_kmp_pattern_match_counter_top.sv
// Testbench top that drives pattern and text transactions into the KMP pattern match counter.
module tb_kmp_pattern_match_counter_top;
    import kpmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int ITEM_TARGET  = 1700;
    localparam int LONG_HOLD    = 400;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_kind = KIND_PATTERN;
    logic [SYM_W-1:0] s_symbol = '0;
    logic             s_last = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_match_found;
    logic [OUT_W-1:0] m_match_start;
    logic [OUT_W-1:0] m_match_total;
    logic             m_text_done;

    int               mismatches;
    int               outstanding;
    int               cycle_count = 0;
    int               items_sent = 0;
    bit               calm = 1'b0;
    bit               hold_long = 1'b0;
    logic [SYM_W-1:0] pat_buf [0:79];
    logic [SYM_W-1:0] txt_buf [0:127];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    kmp_pattern_match_counter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_symbol      (s_symbol),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_found (m_match_found),
        .m_match_start (m_match_start),
        .m_match_total (m_match_total),
        .m_text_done   (m_text_done)
    );

    kmp_pattern_match_counter_checker match_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_symbol      (s_symbol),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_found (m_match_found),
        .m_match_start (m_match_start),
        .m_match_total (m_match_total),
        .m_text_done   (m_text_done),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    task automatic offer_byte(input logic kind, input logic [SYM_W-1:0] sym, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_kind   <= kind;
        s_symbol <= sym;
        s_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        @(posedge aclk);
    endtask

    initial begin : receiver
        int stall;
        repeat (2) @(posedge aclk);
        forever begin
            if (hold_long) begin
                stall = LONG_HOLD;
                hold_long = 1'b0;
            end else begin
                stall = calm ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int episode;
        int plen;
        int tlen;
        int n;
        int split;
        int interrupt_at;
        int copy;
        bit noisy;
        bit long_run;
        bit keep_open;
        logic [SYM_W-1:0] alpha [0:2];

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Text against an empty pattern, then overlapping matches of two patterns.
        offer_byte(KIND_TEXT, 8'h00, 1'b0);
        offer_byte(KIND_TEXT, 8'hFF, 1'b1);
        offer_byte(KIND_PATTERN, 8'h00, 1'b0);
        offer_byte(KIND_PATTERN, 8'h00, 1'b1);
        offer_byte(KIND_TEXT, 8'h00, 1'b0);
        offer_byte(KIND_TEXT, 8'h00, 1'b0);
        offer_byte(KIND_TEXT, 8'h00, 1'b0);
        offer_byte(KIND_TEXT, 8'hFF, 1'b1);
        offer_byte(KIND_PATTERN, 8'hFF, 1'b0);
        offer_byte(KIND_PATTERN, 8'h80, 1'b0);
        offer_byte(KIND_PATTERN, 8'hFF, 1'b1);
        offer_byte(KIND_TEXT, 8'hFF, 1'b0);
        offer_byte(KIND_TEXT, 8'h80, 1'b0);
        offer_byte(KIND_TEXT, 8'hFF, 1'b0);
        offer_byte(KIND_TEXT, 8'h80, 1'b0);
        offer_byte(KIND_TEXT, 8'hFF, 1'b1);
        // A new pattern arrives in the middle of a text.
        offer_byte(KIND_TEXT, 8'hFF, 1'b0);
        offer_byte(KIND_PATTERN, 8'h01, 1'b1);
        offer_byte(KIND_TEXT, 8'h01, 1'b0);
        offer_byte(KIND_TEXT, 8'h01, 1'b1);

        episode = 0;
        while (items_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            noisy = ($urandom_range(0, 9) == 0);
            long_run = ($urandom_range(0, 14) == 0) || (episode == 3);
            for (int i = 0; i < 3; i++) alpha[i] = SYM_W'($urandom_range(0, 255));

            plen = long_run ? $urandom_range(60, 72) : $urandom_range(1, 6);
            for (int i = 0; i < plen; i++) begin
                if (noisy) pat_buf[i] = SYM_W'($urandom_range(0, 255));
                else if (long_run) pat_buf[i] = ($urandom_range(0, 15) == 0) ? alpha[1] : alpha[0];
                else pat_buf[i] = alpha[$urandom_range(0, 2)];
            end

            split = (plen > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, plen - 1) : plen;
            for (int i = 0; i < plen; i++) begin
                if (i == split) begin
                    for (int t = 0; t < 3; t++) offer_byte(KIND_TEXT, alpha[$urandom_range(0, 2)], 1'b0);
                end
                offer_byte(KIND_PATTERN, pat_buf[i], i == plen - 1);
                // Bytes past the store limit are dropped by the block.
                if (i >= MAX_PATTERN_DEF) items_sent--;
            end

            if (episode == 5 || episode == 60) hold_long = 1'b1;

            tlen = long_run ? $urandom_range(70, 110) : $urandom_range(1, 40);
            n = 0;
            while (n < tlen) begin
                if (!noisy && plen <= 8 && $urandom_range(0, 2) == 0) begin
                    for (copy = 0; copy < plen && n < tlen; copy++) begin
                        txt_buf[n] = pat_buf[copy];
                        n++;
                    end
                    if ($urandom_range(0, 3) == 0) txt_buf[n-1] = alpha[$urandom_range(0, 2)];
                end else begin
                    if (noisy) txt_buf[n] = SYM_W'($urandom_range(0, 255));
                    else if (long_run) txt_buf[n] = ($urandom_range(0, 11) == 0) ? alpha[1] : alpha[0];
                    else txt_buf[n] = alpha[$urandom_range(0, 2)];
                    n++;
                end
            end

            keep_open = ($urandom_range(0, 9) == 0);
            interrupt_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, tlen - 1) : -1;
            for (int i = 0; i < tlen; i++) begin
                if (i == interrupt_at) offer_byte(KIND_PATTERN, alpha[0], 1'b1);
                offer_byte(KIND_TEXT, txt_buf[i], (i == tlen - 1) && !keep_open);
            end

            if (episode == 10 || $urandom_range(0, 5) == 0) drain_results();
            episode++;
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: kmp_pattern_match_counter_top.f
+incdir+src
src/kpmc_pkg.sv
src/kpmc_ram.sv
src/kpmc_core.sv
src/kmp_pattern_match_counter_top.sv
src/kpmc_checker.sv
tb/kmp_pattern_match_counter_checker.sv
tb/tb_kmp_pattern_match_counter_top.sv
